// ----- src/ans_pkg.sv -----
// ----------------------------------------------------------------------------
// ADC noise statistics package
// Shared widths and the structures passed to the statistics calculator.
// ----------------------------------------------------------------------------
package ans_pkg;

   localparam int CHANNELS = 4;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 28;
   localparam int SQSUM_W  = 44;
   localparam int FRAMES_W = 13;

   typedef struct packed {
      logic                start;
      logic [SUM_W-1:0]    sum;
      logic [SQSUM_W-1:0]  sqsum;
      logic [FRAMES_W-1:0] frames;
   } ans_job_type;

   typedef struct packed {
      logic                done;
      logic [SAMPLE_W-1:0] mean;
      logic [SAMPLE_W-1:0] deviation;
   } ans_res_type;

endpackage

// ----- src/adc_noise_statistics.sv -----
// ----------------------------------------------------------------------------
// ADC noise statistics
// Per-channel minimum, maximum, mean, peak-to-peak and standard deviation
// over a capture of ADC frames.
// ----------------------------------------------------------------------------
// A frame beat is taken as one accept, a square and an accumulate step per
// channel on the shared 16x16 squarer, and one target compare.
// The frame that completes a capture starts the calculator on channel 0;
// each later channel starts once the previous result beat is taken on
// rsp_tready (products, two 57-step divisions, 16-step square root).
// Synchronous reset clears the capture, requests 1024 frames; no frame is
// taken while results are pending.
module adc_noise_statistics #(
   parameter int MIN_SAMPLES = 16,
   parameter int MAX_SAMPLES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sample_a, sample_b, sample_c, sample_bus
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // lowest, highest, average, spread, deviation, frames_used, zero fill
   output logic [95:0] rsp_tdata,
   // channel
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_ACC   = 3'd1;
   localparam logic [2:0] T_CHECK = 3'd2;
   localparam logic [2:0] T_CALC  = 3'd3;
   localparam logic [2:0] T_OUT   = 3'd4;

   localparam int SW = ans_pkg::SAMPLE_W;
   localparam int FW = ans_pkg::FRAMES_W;
   localparam logic [15:0]   MinCount = 16'(MIN_SAMPLES);
   localparam logic [15:0]   MaxCount = 16'(MAX_SAMPLES);
   localparam logic [1:0]    LastChannel = 2'(ans_pkg::CHANNELS - 1);

   logic [2:0]    state_ff, state_in;
   logic [1:0]    ch_ff, ch_in;
   logic          phase_ff, phase_in;
   logic [SW-1:0] frame_ff [ans_pkg::CHANNELS];
   logic [SW-1:0] frame_in [ans_pkg::CHANNELS];
   logic [31:0]   prod_ff, prod_in;
   logic [ans_pkg::SUM_W-1:0]   sum_ff [ans_pkg::CHANNELS];
   logic [ans_pkg::SUM_W-1:0]   sum_in [ans_pkg::CHANNELS];
   logic [ans_pkg::SQSUM_W-1:0] sqsum_ff [ans_pkg::CHANNELS];
   logic [ans_pkg::SQSUM_W-1:0] sqsum_in [ans_pkg::CHANNELS];
   logic [SW-1:0] min_ff [ans_pkg::CHANNELS];
   logic [SW-1:0] min_in [ans_pkg::CHANNELS];
   logic [SW-1:0] max_ff [ans_pkg::CHANNELS];
   logic [SW-1:0] max_in [ans_pkg::CHANNELS];
   logic [FW-1:0] frames_ff, frames_in;
   logic [15:0]   request_ff, request_in;
   logic          start_ff, start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [95:0]   rsp_data_ff, rsp_data_in;
   logic [1:0]    rsp_user_ff, rsp_user_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [15:0]   low_clamped;
   logic [15:0]   target;
   logic [SW-1:0] sample;
   logic          first;
   ans_pkg::ans_job_type job;
   ans_pkg::ans_res_type res;

   ans_math u_math (
      .clock (clock),
      .reset (reset),
      .job   (job),
      .res   (res)
   );

   always_comb begin
      low_clamped = (request_ff < MinCount) ? MinCount : request_ff;
      target      = (low_clamped > MaxCount) ? MaxCount : low_clamped;
      sample      = frame_ff[ch_ff];
      first       = frames_ff == '0;
      job.start   = start_ff;
      job.sum     = sum_ff[ch_ff];
      job.sqsum   = sqsum_ff[ch_ff];
      job.frames  = frames_ff;
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      phase_in     = phase_ff;
      frame_in     = frame_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      sqsum_in     = sqsum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      frames_in    = frames_ff;
      request_in   = (csr_valid && csr_ready) ? csr_data : request_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_tvalid) begin
               for (int i = 0; i < ans_pkg::CHANNELS; i++) begin
                  frame_in[i] = req_tdata[i*SW +: SW];
               end
               state_in = T_ACC;
               ch_in    = '0;
               phase_in = 1'b0;
            end
         end
         T_ACC: begin
            phase_in = ~phase_ff;
            if (!phase_ff) begin
               prod_in = 32'(sample) * 32'(sample);
            end else begin
               sum_in[ch_ff]   = sum_ff[ch_ff] + ans_pkg::SUM_W'(sample);
               sqsum_in[ch_ff] = sqsum_ff[ch_ff] + ans_pkg::SQSUM_W'(prod_ff);
               // The first frame of a capture seeds the extremes.
               if (first || sample < min_ff[ch_ff]) begin
                  min_in[ch_ff] = sample;
               end
               if (first || sample > max_ff[ch_ff]) begin
                  max_in[ch_ff] = sample;
               end
               ch_in = ch_ff + 2'd1;
               if (ch_ff == LastChannel) begin
                  frames_in = frames_ff + FW'(1);
                  state_in  = T_CHECK;
               end
            end
         end
         T_CHECK: begin
            if (16'(frames_ff) >= target) begin
               state_in = T_CALC;
               start_in = 1'b1;
            end else begin
               state_in = T_IDLE;
            end
         end
         T_CALC: begin
            if (res.done) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'd0, frames_ff, res.deviation,
                               16'(max_ff[ch_ff] - min_ff[ch_ff]), res.mean,
                               max_ff[ch_ff], min_ff[ch_ff]};
               rsp_user_in  = ch_ff;
               rsp_last_in  = ch_ff == LastChannel;
               state_in     = T_OUT;
            end
         end
         T_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               ch_in        = ch_ff + 2'd1;
               if (ch_ff == LastChannel) begin
                  state_in  = T_IDLE;
                  frames_in = '0;
                  for (int i = 0; i < ans_pkg::CHANNELS; i++) begin
                     sum_in[i]   = '0;
                     sqsum_in[i] = '0;
                  end
               end else begin
                  state_in = T_CALC;
                  start_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         ch_ff        <= '0;
         phase_ff     <= 1'b0;
         frames_ff    <= '0;
         request_ff   <= 16'd1024;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ans_pkg::CHANNELS; i++) begin
            sum_ff[i]   <= '0;
            sqsum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         phase_ff     <= phase_in;
         frames_ff    <= frames_in;
         request_ff   <= request_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         sqsum_ff     <= sqsum_in;
      end
      frame_ff    <= frame_in;
      prod_ff     <= prod_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = state_ff == T_IDLE;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- src/ans_math.sv -----
// ----------------------------------------------------------------------------
// ADC noise statistics calculator
// Bit-serial mean and standard deviation of one channel: shift-add products,
// restoring division and a two-bit-per-step integer square root.
// ----------------------------------------------------------------------------
module ans_math (
   input  logic                 clock,
   input  logic                 reset,
   input  ans_pkg::ans_job_type job,
   output ans_pkg::ans_res_type res
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DEN  = 3'd1;
   localparam logic [2:0] ST_SQ   = 3'd2;
   localparam logic [2:0] ST_NUM  = 3'd3;
   localparam logic [2:0] ST_MEAN = 3'd4;
   localparam logic [2:0] ST_VAR  = 3'd5;
   localparam logic [2:0] ST_ROOT = 3'd6;

   localparam logic [5:0] N_STEPS   = 6'd13;
   localparam logic [5:0] SUM_STEPS = 6'd28;
   localparam logic [5:0] DIV_STEPS = 6'd57;
   localparam logic [5:0] SQ_STEPS  = 6'd16;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [56:0] acc_ff, acc_in;
   logic [43:0] mcand_ff, mcand_in;
   logic [27:0] mplier_ff, mplier_in;
   logic [24:0] den_ff, den_in;
   logic [55:0] sq_ff, sq_in;
   logic [56:0] num_ff, num_in;
   logic [56:0] dvd_ff, dvd_in;
   logic [24:0] dvs_ff, dvs_in;
   logic [24:0] rem_ff, rem_in;
   logic [15:0] mean_ff, mean_in;
   logic [31:0] rad_ff, rad_in;
   logic [16:0] rrem_ff, rrem_in;
   logic [15:0] root_ff, root_in;
   logic        done_ff, done_in;

   logic [56:0] acc_step;
   logic [25:0] rem_sh;
   logic        div_ge;
   logic [24:0] rem_step;
   logic [56:0] dvd_step;
   logic [18:0] rr;
   logic [18:0] trial;
   logic        root_ge;
   logic [56:0] diff;
   logic        last;

   always_comb begin
      acc_step = {acc_ff[55:0], 1'b0} + (mplier_ff[27] ? 57'(mcand_ff) : 57'd0);
      rem_sh   = {rem_ff, dvd_ff[56]};
      div_ge   = rem_sh >= {1'b0, dvs_ff};
      rem_step = div_ge ? 25'(rem_sh - {1'b0, dvs_ff}) : rem_sh[24:0];
      dvd_step = {dvd_ff[55:0], div_ge};
      rr       = {rrem_ff, rad_ff[31:30]};
      trial    = {1'b0, root_ff, 2'b01};
      root_ge  = rr >= trial;
      diff     = (num_ff >= {1'b0, sq_ff}) ? (num_ff - {1'b0, sq_ff}) : 57'd0;
      last     = cnt_ff == 6'd1;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff - 6'd1;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      den_in    = den_ff;
      sq_in     = sq_ff;
      num_in    = num_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      mean_in   = mean_ff;
      rad_in    = rad_ff;
      rrem_in   = rrem_ff;
      root_in   = root_ff;
      done_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = cnt_ff;
            if (job.start) begin
               state_in  = ST_DEN;
               acc_in    = '0;
               mcand_in  = 44'(job.frames);
               mplier_in = {job.frames, 15'd0};
               cnt_in    = N_STEPS;
            end
         end
         ST_DEN, ST_SQ, ST_NUM: begin
            // Multiplier bits are consumed from the top, one per cycle.
            acc_in    = acc_step;
            mplier_in = {mplier_ff[26:0], 1'b0};
            if (last) begin
               acc_in = '0;
               if (state_ff == ST_DEN) begin
                  den_in    = acc_step[24:0];
                  state_in  = ST_SQ;
                  mcand_in  = 44'(job.sum);
                  mplier_in = job.sum;
                  cnt_in    = SUM_STEPS;
               end else if (state_ff == ST_SQ) begin
                  sq_in     = acc_step[55:0];
                  state_in  = ST_NUM;
                  mcand_in  = job.sqsum;
                  mplier_in = {job.frames, 15'd0};
                  cnt_in    = N_STEPS;
               end else begin
                  num_in   = acc_step;
                  state_in = ST_MEAN;
                  dvd_in   = 57'(job.sum) + 57'(job.frames[12:1]);
                  dvs_in   = 25'(job.frames);
                  rem_in   = '0;
                  cnt_in   = DIV_STEPS;
               end
            end
         end
         ST_MEAN, ST_VAR: begin
            dvd_in = dvd_step;
            rem_in = rem_step;
            if (last) begin
               if (state_ff == ST_MEAN) begin
                  mean_in  = dvd_step[15:0];
                  state_in = ST_VAR;
                  dvd_in   = diff + 57'(den_ff[24:1]);
                  dvs_in   = den_ff;
                  rem_in   = '0;
                  cnt_in   = DIV_STEPS;
               end else begin
                  // The population variance of 16-bit codes stays below 2^31.
                  state_in = ST_ROOT;
                  rad_in   = dvd_step[31:0];
                  rrem_in  = '0;
                  root_in  = '0;
                  cnt_in   = SQ_STEPS;
               end
            end
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[29:0], 2'b00};
            rrem_in = root_ge ? 17'(rr - trial) : rr[16:0];
            root_in = {root_ff[14:0], root_ge};
            if (last) begin
               state_in = ST_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      den_ff    <= den_in;
      sq_ff     <= sq_in;
      num_ff    <= num_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      mean_ff   <= mean_in;
      rad_ff    <= rad_in;
      rrem_ff   <= rrem_in;
      root_ff   <= root_in;
   end

   assign res.done      = done_ff;
   assign res.mean      = mean_ff;
   assign res.deviation = root_ff;

endmodule

// ----- src/ans_check.sv -----
// ----------------------------------------------------------------------------
// ADC noise statistics port checker
// Watches the top-level ports for result consistency and handshake order.
// ----------------------------------------------------------------------------
module ans_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:48] == 16'(rsp_tdata[31:16] - rsp_tdata[15:0]))
      else $error("spread does not match the extremes");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] >= rsp_tdata[15:0]
         && rsp_tdata[47:32] >= rsp_tdata[15:0] && rsp_tdata[47:32] <= rsp_tdata[31:16])
      else $error("mean outside the extremes");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tuser == 2'd3))
      else $error("last flag on the wrong channel");

   a_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("frame taken while results are pending");

endmodule

bind adc_noise_statistics ans_check u_ans_check (.*);
